// ----- hw/rtl/fpq_pkg.sv -----
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types, command codes and saturation helper for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpq_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MAX      = 4'd10,
    CMD_MIN      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // quotient bits resolved by the divider, one per stage
  localparam int unsigned DIV_STEPS = 33;
  // divider: overflow precheck + steps + round/clamp
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned MUL_LAT   = 2;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        neg;
    logic        b_zero;
  } op_t;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  status;
  } res_t;

  // sign + magnitude to 32-bit signed, saturating
  function automatic res_t sat_mag(input logic neg, input logic [33:0] mag);
    res_t r;
    r.flag = 1'b0;
    if (!neg && (mag > {2'b00, POS_MAX})) begin
      r.value  = POS_MAX;
      r.status = ST_OVF;
    end else if (neg && (mag > {2'b00, NEG_MIN})) begin
      r.value  = NEG_MIN;
      r.status = ST_OVF;
    end else begin
      r.value  = neg ? (32'd0 - mag[31:0]) : mag[31:0];
      r.status = ST_OK;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/fpq_front.sv -----
// ----------------------------------------------------------------------------
// fpq_front
// Input stage: registered results of the simple ops, and operand magnitudes for mul/div.
// ----------------------------------------------------------------------------
module fpq_front import fpq_pkg::*; #(
  parameter int unsigned FracBits = 8
) (
  input  logic        clk_i,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output res_t        res_o,
  output op_t         op_o
);

  logic signed [31:0] a, b;
  logic [32:0]        sum, dif, incr, decr;
  logic [63:0]        shl;
  res_t               res_d, res_q;
  op_t                op_d, op_q;

  assign a = $signed(operand_a_i);
  assign b = $signed(operand_b_i);

  assign sum  = {a[31], a} + {b[31], b};
  assign dif  = {a[31], a} - {b[31], b};
  assign incr = {a[31], a} + 33'd1;
  assign decr = {a[31], a} - 33'd1;
  assign shl  = {{32{a[31]}}, a} << FracBits;

  function automatic res_t clamp33(input logic [32:0] v);
    res_t r;
    r.flag   = 1'b0;
    r.status = (v[32] != v[31]) ? ST_OVF : ST_OK;
    if (v[32] != v[31]) r.value = v[32] ? NEG_MIN : POS_MAX;
    else                r.value = v[31:0];
    return r;
  endfunction

  always_comb begin
    res_d = '{value: 32'd0, flag: 1'b0, status: ST_OK};
    case (cmd_e'(command_i))
      CMD_ADD: res_d = clamp33(sum);
      CMD_SUB: res_d = clamp33(dif);
      CMD_INC: res_d = clamp33(incr);
      CMD_DEC: res_d = clamp33(decr);
      CMD_GT:  res_d.flag = a > b;
      CMD_LT:  res_d.flag = a < b;
      CMD_GE:  res_d.flag = a >= b;
      CMD_LE:  res_d.flag = a <= b;
      CMD_EQ:  res_d.flag = a == b;
      CMD_NE:  res_d.flag = a != b;
      CMD_MAX: res_d.value = (a > b) ? a : b;
      CMD_MIN: res_d.value = (a < b) ? a : b;
      CMD_FROM_INT: begin
        if ((shl[63:31] != '0) && (shl[63:31] != '1)) begin
          res_d.value  = a[31] ? NEG_MIN : POS_MAX;
          res_d.status = ST_OVF;
        end else begin
          res_d.value = shl[31:0];
        end
      end
      CMD_TO_INT: res_d.value = a >>> FracBits;
      default: ;  // mul/div resolved downstream
    endcase
  end

  always_comb begin
    op_d.mag_a  = a[31] ? (32'd0 - a) : a;
    op_d.mag_b  = b[31] ? (32'd0 - b) : b;
    op_d.neg    = a[31] ^ b[31];
    op_d.b_zero = (b == 32'sd0);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    op_q  <= op_d;
  end

  assign res_o = res_q;
  assign op_o  = op_q;

endmodule

// ----- hw/rtl/fpq_mul.sv -----
// ----------------------------------------------------------------------------
// fpq_mul
// Two-stage magnitude multiply, round half away from zero, saturate.
// ----------------------------------------------------------------------------
module fpq_mul import fpq_pkg::*; #(
  parameter int unsigned FracBits = 8
) (
  input  logic clk_i,
  input  op_t  op_i,
  output res_t res_o
);

  logic [63:0] prod_q;
  logic        neg_q;
  logic [63:0] rnd;
  logic [33:0] mag;
  res_t        res_q;

  assign rnd = (prod_q + (64'd1 << (FracBits - 1))) >> FracBits;
  assign mag = (|rnd[63:34]) ? '1 : rnd[33:0];

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(op_i.mag_a) * 64'(op_i.mag_b);
    neg_q  <= op_i.neg;
    res_q  <= sat_mag(neg_q, mag);
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/fpq_div.sv -----
// ----------------------------------------------------------------------------
// fpq_div
// Pipelined restoring divider, one quotient bit per stage, rounded result.
// ----------------------------------------------------------------------------
module fpq_div import fpq_pkg::*; #(
  parameter int unsigned FracBits = 8
) (
  input  logic clk_i,
  input  op_t  op_i,
  output res_t res_o
);

  localparam int unsigned NW = 32 + FracBits;

  logic [NW-1:0] num;
  logic [NW-1:0] num_hi;

  // stage 0 is the precheck, stages 1..DIV_STEPS each resolve a bit
  logic [31:0]          rem_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] nlo_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q  [DIV_STEPS+1];
  logic [31:0]          den_q  [DIV_STEPS+1];
  logic                 neg_q  [DIV_STEPS+1];
  logic                 zero_q [DIV_STEPS+1];
  logic                 ovf_q  [DIV_STEPS+1];

  logic [32:0] trial  [DIV_STEPS];
  logic        ge     [DIV_STEPS];

  logic        rnd_up;
  logic [33:0] mag;
  res_t        res_d, res_q;

  assign num    = {op_i.mag_a, {FracBits{1'b0}}};
  assign num_hi = num >> DIV_STEPS;

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial[i] = {rem_q[i], nlo_q[i][DIV_STEPS-1]};
      ge[i]    = trial[i] >= {1'b0, den_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    // quotient >= 2^33 saturates anyway
    ovf_q[0]  <= num_hi >= NW'(op_i.mag_b);
    rem_q[0]  <= num_hi[31:0];
    nlo_q[0]  <= num[DIV_STEPS-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= op_i.mag_b;
    neg_q[0]  <= op_i.neg;
    zero_q[0] <= op_i.b_zero;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_q[i+1]  <= ge[i] ? 32'(trial[i] - {1'b0, den_q[i]}) : trial[i][31:0];
      nlo_q[i+1]  <= nlo_q[i] << 1;
      quo_q[i+1]  <= {quo_q[i][DIV_STEPS-2:0], ge[i]};
      den_q[i+1]  <= den_q[i];
      neg_q[i+1]  <= neg_q[i];
      zero_q[i+1] <= zero_q[i];
      ovf_q[i+1]  <= ovf_q[i];
    end
  end

  // round half away: bump when twice the remainder reaches the divisor
  assign rnd_up = {rem_q[DIV_STEPS], 1'b0} >= {1'b0, den_q[DIV_STEPS]};
  assign mag    = ovf_q[DIV_STEPS] ? '1
                : ({1'b0, quo_q[DIV_STEPS]} + 34'(rnd_up));

  always_comb begin
    if (zero_q[DIV_STEPS]) begin
      res_d = '{value: 32'd0, flag: 1'b0, status: ST_DIVZ};
    end else begin
      res_d = sat_mag(neg_q[DIV_STEPS], mag);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/fixed_point_q24_8_alu_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Every command passes the front registers, the alignment line and the output register on its way to done_o.
// Throughput: one beat per cycle; busy is never raised.
// The divider (33 stages, one quotient bit each) sets the depth; all other
// commands ride a delay line so results leave in order.
// Reset clears only the valid bits; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit import fpq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] result_value_o,
  output logic        compare_flag_o,
  output logic [1:0]  status_o
);

  // stage 1: front registers
  res_t front_res;
  op_t  front_op;
  logic v1_q;
  cmd_e cmd1_q;

  // mul/div results
  res_t mul_res;
  res_t div_res;

  // alignment lines, last entry lines up with the divider output
  logic valid_q [DIV_LAT];
  cmd_e cmd_q   [DIV_LAT];
  res_t simp_q  [DIV_LAT];
  res_t mul_q   [DIV_LAT-MUL_LAT];

  res_t out_d;
  res_t out_q;
  logic done_q;

  assign busy = 1'b0;

  fpq_front #(.FracBits(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .res_o       (front_res),
    .op_o        (front_op)
  );

  fpq_mul #(.FracBits(FRAC_BITS)) u_mul (
    .clk_i (clk_i),
    .op_i  (front_op),
    .res_o (mul_res)
  );

  fpq_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i (clk_i),
    .op_i  (front_op),
    .res_o (div_res)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) valid_q[i] <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q       <= start;
      valid_q[0] <= v1_q;
      for (int i = 1; i < DIV_LAT; i++) valid_q[i] <= valid_q[i-1];
      done_q <= valid_q[DIV_LAT-1];
    end
  end

  // payload lines, no reset
  always_ff @(posedge clk_i) begin
    cmd1_q    <= cmd_e'(command_i);
    cmd_q[0]  <= cmd1_q;
    simp_q[0] <= front_res;
    mul_q[0]  <= mul_res;
    for (int i = 1; i < DIV_LAT; i++) begin
      cmd_q[i]  <= cmd_q[i-1];
      simp_q[i] <= simp_q[i-1];
    end
    for (int i = 1; i < DIV_LAT - MUL_LAT; i++) mul_q[i] <= mul_q[i-1];
    out_q <= out_d;
  end

  // pick the unit that owns this command
  always_comb begin
    case (cmd_q[DIV_LAT-1])
      CMD_MUL: out_d = mul_q[DIV_LAT-MUL_LAT-1];
      CMD_DIV: out_d = div_res;
      default: out_d = simp_q[DIV_LAT-1];
    endcase
  end

  assign done_o         = done_q;
  assign result_value_o = out_q.value;
  assign compare_flag_o = out_q.flag;
  assign status_o       = out_q.status;

endmodule

// ----- tb/fixed_point_q24_8_alu_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_checker
// Watches the command and result channels, computes the expected Q24.8
// result of every accepted command and compares it, in order, with each
// result beat.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_checker import fpq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        done_i,
  input  logic [31:0] result_value_i,
  input  logic        compare_flag_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  typedef struct {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  status;
  } alu_res_t;

  alu_res_t expected_results[$];
  int       fails   = 0;
  int       results = 0;

  // clamp a wide signed value to 32 bits
  function automatic alu_res_t sat_wide(input longint v);
    alu_res_t r;
    r.flag   = 1'b0;
    r.status = ST_OK;
    if (v > 64'sd2147483647) begin
      r.value  = POS_MAX;
      r.status = ST_OVF;
    end else if (v < -64'sd2147483648) begin
      r.value  = NEG_MIN;
      r.status = ST_OVF;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

  function automatic alu_res_t compute_alu(input cmd_e cmd, input logic [31:0] ra,
                                           input logic [31:0] rb);
    alu_res_t    r;
    longint      a;
    longint      b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic        neg;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    r.value  = '0;
    r.flag   = 1'b0;
    r.status = ST_OK;
    case (cmd)
      CMD_ADD: r = sat_wide(a + b);
      CMD_SUB: r = sat_wide(a - b);
      CMD_MUL, CMD_DIV: begin
        if (cmd == CMD_DIV && b == 0) begin
          r.status = ST_DIVZ;
        end else begin
          if (cmd == CMD_MUL)
            q = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          else
            q = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
          r = sat_wide(neg ? -longint'(q) : longint'(q));
        end
      end
      CMD_GT:  r.flag = a > b;
      CMD_LT:  r.flag = a < b;
      CMD_GE:  r.flag = a >= b;
      CMD_LE:  r.flag = a <= b;
      CMD_EQ:  r.flag = a == b;
      CMD_NE:  r.flag = a != b;
      CMD_MAX: r.value = (a > b) ? ra : rb;
      CMD_MIN: r.value = (a < b) ? ra : rb;
      CMD_INC: r = sat_wide(a + 1);
      CMD_DEC: r = sat_wide(a - 1);
      CMD_FROM_INT: r = sat_wide(a * (64'sd1 <<< FRAC_BITS));
      default: r.value = $signed(ra) >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fails++;
  endtask

  assign fail_count_o   = fails;
  assign result_count_o = results;
  assign pending_o      = expected_results.size();

  always @(posedge clk_i) begin
    alu_res_t e;
    if (rst_ni) begin
      if (start_i && !busy_i)
        expected_results.push_back(compute_alu(cmd_e'(command_i), operand_a_i,
                                               operand_b_i));
      if (done_i) begin
        results++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", result_value_i, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (result_value_i !== e.value)
            report_mismatch("result_value", result_value_i, e.value);
          if (compare_flag_i !== e.flag)
            report_mismatch("compare_flag", {31'd0, compare_flag_i}, {31'd0, e.flag});
          if (status_i !== e.status)
            report_mismatch("status", {30'd0, status_i}, {30'd0, e.status});
        end
      end
    end
  end

endmodule

// ----- tb/tb_fixed_point_q24_8_alu_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu_unit
// Drives directed corner commands and random commands with varying sender
// gaps into the ALU; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu_unit import fpq_pkg::*;;

  localparam int unsigned N_RANDOM  = 1300;
  localparam int          MAX_CYCLE = 200000;
  localparam int          DRAIN     = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  command_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        done_o;
  logic [31:0] result_value_o;
  logic        compare_flag_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending;
  int          result_count;
  int          cycle_count = 0;
  int          idle_pct = 0;

  always #6 clk_i = ~clk_i;

  fixed_point_q24_8_alu_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .operand_a_i, .operand_b_i,
    .done_o, .result_value_o, .compare_flag_o, .status_o
  );

  fixed_point_q24_8_alu_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .operand_a_i,
    .operand_b_i, .done_i(done_o), .result_value_i(result_value_o),
    .compare_flag_i(compare_flag_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("fixed_point_q24_8_alu_unit: mismatch");
      $finish;
    end
  end

  // one beat: optional random gap, then hold start until accepted
  task automatic send_beat(input cmd_e cmd, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    command_i   <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // operands biased toward edges and small fixed-point values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(1023) - 512;
      3: return ($urandom_range(2000) - 1000) << 8;
      4: return $urandom_range(1) ? 32'h0000_0080 : 32'hFFFF_FF80;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: saturation, div by zero, rounding ties, equal-operand max, min
    send_beat(CMD_ADD, POS_MAX, 32'd1);
    send_beat(CMD_SUB, NEG_MIN, 32'd1);
    send_beat(CMD_MUL, POS_MAX, POS_MAX);
    send_beat(CMD_MUL, NEG_MIN, NEG_MIN);
    send_beat(CMD_MUL, NEG_MIN, 32'h0000_0100);
    send_beat(CMD_MUL, 32'h0000_0001, 32'h0000_0080);   // exact half
    send_beat(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080);   // negative half
    send_beat(CMD_DIV, 32'h0000_0100, 32'd0);
    send_beat(CMD_DIV, NEG_MIN, 32'd1);
    send_beat(CMD_DIV, NEG_MIN, 32'hFFFF_FF00);
    send_beat(CMD_DIV, 32'h0000_0001, 32'h0000_0200);   // 0.5 LSB tie
    send_beat(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
    send_beat(CMD_GT, NEG_MIN, POS_MAX);
    send_beat(CMD_LT, NEG_MIN, POS_MAX);
    send_beat(CMD_GE, 32'd5, 32'd5);
    send_beat(CMD_LE, 32'd5, 32'd5);
    send_beat(CMD_EQ, POS_MAX, POS_MAX);
    send_beat(CMD_NE, POS_MAX, NEG_MIN);
    send_beat(CMD_MAX, 32'd7, 32'd7);
    send_beat(CMD_MIN, NEG_MIN, POS_MAX);
    send_beat(CMD_INC, POS_MAX, 32'hFFFF_FFFF);
    send_beat(CMD_DEC, NEG_MIN, 32'hFFFF_FFFF);
    send_beat(CMD_FROM_INT, 32'h0080_0000, 32'd0);
    send_beat(CMD_FROM_INT, 32'hFF7F_FFFF, 32'd0);
    send_beat(CMD_TO_INT, 32'hFFFF_FF01, 32'd0);

    // random: three idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_pct = (i < N_RANDOM / 3) ? 28 : (i < 2 * N_RANDOM / 3) ? 53 : 0;
      a = pick_operand();
      b = $urandom_range(7) == 0 ? a : pick_operand();
      send_beat(cmd_e'($urandom_range(15)), a, b);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("ran %0d commands (%0d results) over all 16 opcodes,", N_RANDOM + 25,
             result_count);
    $display("with saturation, divide-by-zero and rounding-tie corners");
    if (fail_count == 0) begin
      $display("fixed_point_q24_8_alu_unit: match");
    end else begin
      $display("fixed_point_q24_8_alu_unit: mismatch");
    end
    $finish;
  end

endmodule
